>>> rtl/core/ktm_pkg.sv
package ktm_pkg;

    // Default sizing of the edge table
    localparam int NODES_DEF   = 256;
    localparam int SYMBOLS_DEF = 64;

    // Symbol codes fit in six bits ('_', A-Z, a-z give 0..52)
    localparam int SYM_W = 6;

    typedef enum logic
    {
        OP_SCAN   = 1'b0,
        OP_INSERT = 1'b1
    } ktm_op_t;

    // Classified input word, as held in the queue between front and back
    typedef struct packed
    {
        ktm_op_t          op;
        logic             sym_ok;
        logic [SYM_W-1:0] sym;
        logic             is_digit;
        logic             last;
        logic [7:0]       kw_type;
    } ktm_item_t;

endpackage

>>> rtl/core/keyword_trie_matcher.sv
// Keyword matcher over a character stream. Insert words (op=1) add one keyword
// character each and build a trie in an on-chip edge table of NODES*SYMBOLS
// entries; scan words (op=0) walk it. Every word returns one result word, in
// order; a scan result is match started, continues, keyword found (type and length) or none.
// After reset the edge table is cleared one entry per cycle, all NODES*SYMBOLS
// entries, and in_ready stays low until that is done. Each word is then read in
// the back end's read state, which reads the table entry for the current node
// and symbol, then updated in its exec state, which updates the walk state from
// the registered read data, since the next address is the child read back; the
// back end takes no new word until that update is done. A two-word queue in
// front and a result register behind let input and output stall independently;
// the update, and with it the result word, waits while the output stalls.
module keyword_trie_matcher
#(
    parameter int NODES   = ktm_pkg::NODES_DEF,
    parameter int SYMBOLS = ktm_pkg::SYMBOLS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    input  logic [7:0]        keyword_type,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        match_event,
    output logic signed [8:0] hit_type,
    output logic [5:0]        found_length,
    output logic              table_full
);
    import ktm_pkg::*;

    ktm_item_t q_head;
    logic      q_valid;
    logic      pop;
    logic      clearing;

    // Front end: classify and queue
    ktm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .char_code    (char_code),
        .last_char    (last_char),
        .keyword_type (keyword_type),
        .clearing     (clearing),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop)
    );

    // Back end: trie table and walk state
    ktm_back
    #(
        .NODES   (NODES),
        .SYMBOLS (SYMBOLS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_event  (match_event),
        .hit_type     (hit_type),
        .found_length (found_length),
        .table_full   (table_full)
    );

endmodule

>>> rtl/core/ktm_front.sv
module ktm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [7:0]          char_code,
    input  logic                last_char,
    input  logic [7:0]          keyword_type,
    input  logic                clearing,
    output logic                q_valid,
    output ktm_pkg::ktm_item_t  q_head,
    input  logic                pop
);
    import ktm_pkg::*;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
    localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A    = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'd122;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'd48;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'd57;
    localparam logic [7:0] UPPER_BIAS      = 8'd64;
    localparam logic [7:0] LOWER_BIAS      = 8'd70;

    ktm_item_t  item_in;
    logic [7:0] diff;
    logic       push;

    ktm_item_t  q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Classify the incoming word into a symbol code
    always_comb
    begin
        item_in.op       = ktm_op_t'(op);
        item_in.last     = last_char;
        item_in.kw_type  = keyword_type;
        item_in.is_digit = (char_code >= CHAR_DIGIT_0) && (char_code <= CHAR_DIGIT_9);
        item_in.sym_ok   = 1'b0;
        item_in.sym      = '0;
        diff             = '0;
        if (char_code == CHAR_UNDERSCORE)
        begin
            item_in.sym_ok = 1'b1;
        end
        else if ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z))
        begin
            item_in.sym_ok = 1'b1;
            diff           = char_code - UPPER_BIAS;
            item_in.sym    = diff[SYM_W-1:0];
        end
        else if ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z))
        begin
            item_in.sym_ok = 1'b1;
            diff           = char_code - LOWER_BIAS;
            item_in.sym    = diff[SYM_W-1:0];
        end
    end

    // Two-entry queue towards the back end
    assign in_ready = (count_reg != 2'd2) && !clearing;
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("pop from empty queue");
    a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !push)
        else $error("word taken during table clear");
`endif

endmodule

>>> rtl/core/ktm_back.sv
module ktm_back
#(
    parameter int NODES   = ktm_pkg::NODES_DEF,
    parameter int SYMBOLS = ktm_pkg::SYMBOLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  ktm_pkg::ktm_item_t q_head,
    output logic               pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         match_event,
    output logic signed [8:0]  hit_type,
    output logic [5:0]         found_length,
    output logic               table_full
);
    import ktm_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int DEPTH  = NODES * SYMBOLS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] SYM_COUNT = ADDR_W'(SYMBOLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  NODES_CNT = CNT_W'(NODES);
    localparam logic signed [8:0] TYPE_NONE = -9'sd1;
    localparam logic [5:0]        LEN_MAX   = 6'd63;

    typedef enum logic [1:0]
    {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_NAME  = 2'd2,
        EV_FOUND = 2'd3
    } event_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_READ,
        ST_EXEC
    } state_t;

    typedef struct packed
    {
        logic [NODE_W-1:0] child;
        logic              has_child;
        logic              fin;
        logic [7:0]        kw_type;
        logic [5:0]        len;
    } edge_t;

    // Edge table
    edge_t mem [DEPTH];
    edge_t rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    edge_t             wr_data;

    logic [NODE_W-1:0] node_sel;
    logic              fire;
    edge_t             e_new;
    logic              drop_now;

    state_t            state_reg,      state_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    ktm_item_t         cur_reg,        cur_next;
    logic [ADDR_W-1:0] addr_reg,       addr_next;

    // Scan walker
    logic              armed_reg,      armed_next;
    logic              in_name_reg,    in_name_next;
    logic              prev_alnum_reg, prev_alnum_next;
    logic [NODE_W-1:0] snode_reg,      snode_next;
    logic              snode_ok_reg,   snode_ok_next;
    logic              shas_edge_reg,  shas_edge_next;
    logic              sfin_reg,       sfin_next;
    logic [7:0]        stype_reg,      stype_next;
    logic [5:0]        slen_reg,       slen_next;

    // Insert cursor
    logic [NODE_W-1:0] inode_reg,      inode_next;
    logic [5:0]        icount_reg,     icount_next;
    logic              ihas_edge_reg,  ihas_edge_next;
    logic [ADDR_W-1:0] iedge_reg,      iedge_next;
    logic [NODE_W-1:0] ichild_reg,     ichild_next;
    logic              ihas_child_reg, ihas_child_next;
    logic              idrop_reg,      idrop_next;
    logic [CNT_W-1:0]  nfree_reg,      nfree_next;

    // Result register
    logic              out_valid_reg,  out_valid_next;
    event_t            ev_reg,         ev_next;
    logic signed [8:0] ftype_reg,      ftype_next;
    logic [5:0]        flen_reg,       flen_next;
    logic              full_reg,       full_next;

    assign clearing     = (state_reg == ST_CLEAR);
    assign out_valid    = out_valid_reg;
    assign match_event  = ev_reg;
    assign hit_type     = ftype_reg;
    assign found_length = flen_reg;
    assign table_full   = full_reg;

    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign node_sel = (q_head.op == OP_INSERT) ? inode_reg : snode_reg;
    assign rd_addr  = ADDR_W'(node_sel) * SYM_COUNT + ADDR_W'(q_head.sym);

    // Next-state logic: read in the read state, update in the exec state once the result register can take the result
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        cur_next        = cur_reg;
        addr_next       = addr_reg;
        armed_next      = armed_reg;
        in_name_next    = in_name_reg;
        prev_alnum_next = prev_alnum_reg;
        snode_next      = snode_reg;
        snode_ok_next   = snode_ok_reg;
        shas_edge_next  = shas_edge_reg;
        sfin_next       = sfin_reg;
        stype_next      = stype_reg;
        slen_next       = slen_reg;
        inode_next      = inode_reg;
        icount_next     = icount_reg;
        ihas_edge_next  = ihas_edge_reg;
        iedge_next      = iedge_reg;
        ichild_next     = ichild_reg;
        ihas_child_next = ihas_child_reg;
        idrop_next      = idrop_reg;
        nfree_next      = nfree_reg;
        out_valid_next  = out_valid_reg;
        ev_next         = ev_reg;
        ftype_next      = ftype_reg;
        flen_next       = flen_reg;
        full_next       = full_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        e_new           = rd_data_reg;
        drop_now        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clear_addr_reg;
                if (clear_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + ADDR_W'(1);
                end
            end
            ST_READ:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    cur_next   = q_head;
                    addr_next  = rd_addr;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = ST_READ;
                    out_valid_next = 1'b1;
                    ev_next        = EV_NONE;
                    ftype_next     = TYPE_NONE;
                    flen_next      = '0;
                    full_next      = 1'b0;
                    if (cur_reg.op == OP_INSERT)
                    begin
                        armed_next = 1'b1;
                        if (idrop_reg)
                        begin
                            full_next = 1'b1;
                        end
                        else if (cur_reg.sym_ok)
                        begin
                            // allocate a child for a non-final character
                            if (!cur_reg.last && !rd_data_reg.has_child)
                            begin
                                if (nfree_reg < NODES_CNT)
                                begin
                                    e_new.child     = NODE_W'(nfree_reg);
                                    e_new.has_child = 1'b1;
                                    nfree_next      = nfree_reg + CNT_W'(1);
                                    wr_en           = 1'b1;
                                    wr_addr         = addr_reg;
                                    wr_data         = e_new;
                                end
                                else
                                begin
                                    drop_now   = 1'b1;
                                    idrop_next = 1'b1;
                                    full_next  = 1'b1;
                                end
                            end
                            if (!drop_now)
                            begin
                                iedge_next      = addr_reg;
                                ihas_edge_next  = 1'b1;
                                inode_next      = e_new.child;
                                ichild_next     = e_new.child;
                                ihas_child_next = e_new.has_child;
                                if (icount_reg != LEN_MAX)
                                begin
                                    icount_next = icount_reg + 6'd1;
                                end
                            end
                        end
                        // keyword end: mark the final edge, then rewind
                        if (cur_reg.last)
                        begin
                            if (!idrop_next && ihas_edge_next)
                            begin
                                wr_en             = 1'b1;
                                wr_addr           = iedge_next;
                                wr_data.child     = ichild_next;
                                wr_data.has_child = ihas_child_next;
                                wr_data.fin       = 1'b1;
                                wr_data.kw_type   = cur_reg.kw_type;
                                wr_data.len       = icount_next;
                            end
                            inode_next     = '0;
                            icount_next    = '0;
                            ihas_edge_next = 1'b0;
                            iedge_next     = '0;
                            idrop_next     = 1'b0;
                        end
                    end
                    else if (armed_reg)
                    begin
                        if (cur_reg.sym_ok)
                        begin
                            // letters inside a word that did not start a match are ignored
                            if (!(prev_alnum_reg && !in_name_reg))
                            begin
                                prev_alnum_next = 1'b1;
                                if (!snode_ok_reg
                                    || (!rd_data_reg.has_child && !rd_data_reg.fin))
                                begin
                                    in_name_next   = 1'b0;
                                    snode_next     = '0;
                                    snode_ok_next  = 1'b1;
                                    shas_edge_next = 1'b0;
                                    sfin_next      = 1'b0;
                                    stype_next     = '0;
                                    slen_next      = '0;
                                end
                                else
                                begin
                                    sfin_next      = rd_data_reg.fin;
                                    stype_next     = rd_data_reg.kw_type;
                                    slen_next      = rd_data_reg.len;
                                    shas_edge_next = 1'b1;
                                    snode_next     = rd_data_reg.child;
                                    snode_ok_next  = rd_data_reg.has_child;
                                    ev_next        = in_name_reg ? EV_NAME : EV_START;
                                    in_name_next   = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            // non-symbol ends the word; report a finished edge
                            prev_alnum_next = cur_reg.is_digit;
                            if (in_name_reg && !cur_reg.is_digit && shas_edge_reg && sfin_reg)
                            begin
                                ev_next    = EV_FOUND;
                                ftype_next = {1'b0, stype_reg};
                                flen_next  = slen_reg;
                            end
                            in_name_next   = 1'b0;
                            snode_next     = '0;
                            snode_ok_next  = 1'b1;
                            shas_edge_next = 1'b0;
                            sfin_next      = 1'b0;
                            stype_next     = '0;
                            slen_next      = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_READ;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            armed_reg      <= 1'b0;
            in_name_reg    <= 1'b0;
            prev_alnum_reg <= 1'b0;
            snode_reg      <= '0;
            snode_ok_reg   <= 1'b1;
            shas_edge_reg  <= 1'b0;
            sfin_reg       <= 1'b0;
            stype_reg      <= '0;
            slen_reg       <= '0;
            inode_reg      <= '0;
            icount_reg     <= '0;
            ihas_edge_reg  <= 1'b0;
            iedge_reg      <= '0;
            ichild_reg     <= '0;
            ihas_child_reg <= 1'b0;
            idrop_reg      <= 1'b0;
            nfree_reg      <= CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            armed_reg      <= armed_next;
            in_name_reg    <= in_name_next;
            prev_alnum_reg <= prev_alnum_next;
            snode_reg      <= snode_next;
            snode_ok_reg   <= snode_ok_next;
            shas_edge_reg  <= shas_edge_next;
            sfin_reg       <= sfin_next;
            stype_reg      <= stype_next;
            slen_reg       <= slen_next;
            inode_reg      <= inode_next;
            icount_reg     <= icount_next;
            ihas_edge_reg  <= ihas_edge_next;
            iedge_reg      <= iedge_next;
            ichild_reg     <= ichild_next;
            ihas_child_reg <= ihas_child_next;
            idrop_reg      <= idrop_next;
            nfree_reg      <= nfree_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        addr_reg  <= addr_next;
        ev_reg    <= ev_next;
        ftype_reg <= ftype_next;
        flen_reg  <= flen_next;
        full_reg  <= full_next;
    end

    // Edge table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_nfree_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nfree_reg >= CNT_W'(1)) && (nfree_reg <= NODES_CNT))
        else $error("free node counter out of range");
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_CLEAR) || fire))
        else $error("table write outside clear or update");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pop)
        else $error("word popped during table clear");
    a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_reg) |-> ((ev_reg == EV_NONE) && (ftype_reg == TYPE_NONE)))
        else $error("table full flagged on a scan result");
    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (ev_reg == EV_FOUND)) |-> (flen_reg != 6'd0))
        else $error("keyword found with zero length");
`endif

endmodule
